/* src/piecewise_cosine_activation_assert.svh */
// Assertion macros shared by the RTL of the piecewise cosine activation block.
// Each macro expects signals named clk and rst in the scope of its use.
`ifndef PIECEWISE_COSINE_ACTIVATION_ASSERT_SVH
`define PIECEWISE_COSINE_ACTIVATION_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PCA_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pcact assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PCA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pcact assertion failed");

`endif

/* src/pcact_pkg.sv */
`default_nettype none
package pcact_pkg;

  // Width of the normalized window fraction and of the cosine arithmetic.
  localparam int FRAC_Q = 30;
  localparam logic [31:0] PI_Q30 = 32'd3373259426;
  localparam int TAYLOR_TERMS = 9;
  localparam int PERIOD_RESET = 1000000;

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_PERIOD = 3'd0;
  localparam logic [2:0] REG_CONTRACT_BEGIN = 3'd1;
  localparam logic [2:0] REG_RELAX_BEGIN = 3'd2;
  localparam logic [2:0] REG_CONTRACT_LENGTH = 3'd3;
  localparam logic [2:0] REG_RELAX_LENGTH = 3'd4;

  typedef enum logic [1:0] {
    PHASE_IDLE = 2'd0,
    PHASE_CONTRACT = 2'd1,
    PHASE_RELAX = 2'd2
  } phase_t;

  // Control that travels with every request through the pipeline.
  typedef struct packed {
    logic valid;
    phase_t phase;
  } pipe_ctl_t;

  // Taylor divisors (2k-1)(2k) and floor(2^32 / divisor).
  localparam logic [8:0] TAYLOR_DIV [1:9] = '{
    9'd2, 9'd12, 9'd30, 9'd56, 9'd90, 9'd132, 9'd182, 9'd240, 9'd306
  };
  localparam logic [31:0] TAYLOR_RECIP [1:9] = '{
    32'd2147483648, 32'd357913941, 32'd143165576, 32'd76695844, 32'd47721858,
    32'd32537631, 32'd23598721, 32'd17895697, 32'd14035840
  };

endpackage
`default_nettype wire

/* src/pcact_mod.sv */
`default_nettype none
// Window test: distance from the window start, reduced modulo the period
// one quotient bit per stage, then checked against the window length.
module pcact_mod #(
  parameter int TW = 32
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire logic [TW-1:0] t,
  input  wire logic [TW-1:0] begin_tick,
  input  wire logic [TW-1:0] len,
  input  wire logic [TW-1:0] period,
  output logic               out_valid,
  output logic               hit,
  output logic [TW-1:0]      pos
);

  logic [TW-1:0] dvd [0:TW];
  logic [TW-1:0] rem [0:TW];
  logic          ge  [0:TW];
  logic          vld [0:TW];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
    ge[0]  <= (t >= begin_tick);
    dvd[0] <= (t >= begin_tick) ? (t - begin_tick) : (begin_tick - t);
    rem[0] <= '0;
  end

  for (genvar i = 1; i <= TW; i++) begin : g_step
    logic [TW:0] rem_s;
    logic [TW:0] rem_d;
    assign rem_s = {rem[i-1], dvd[i-1][TW-1]};
    assign rem_d = rem_s - {1'b0, period};
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else begin
        vld[i] <= vld[i-1];
      end
      rem[i] <= (rem_s >= {1'b0, period}) ? rem_d[TW-1:0] : rem_s[TW-1:0];
      dvd[i] <= {dvd[i-1][TW-2:0], 1'b0};
      ge[i]  <= ge[i-1];
    end
  end

  logic          in_win;
  logic [TW-1:0] p;
  assign in_win = ge[TW] | (rem[TW] == '0);
  assign p      = ge[TW] ? rem[TW] : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vld[TW];
    end
    hit <= (period != '0) && (len != '0) && in_win && (p < len);
    pos <= p;
  end

endmodule
`default_nettype wire

/* src/pcact_frac.sv */
`default_nettype none
// Restoring division r * 2^30 / len, one quotient bit per stage.
module pcact_frac #(
  parameter int TW = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire pcact_pkg::pipe_ctl_t         in_ctl,
  input  wire logic [TW-1:0]                r,
  input  wire logic [TW-1:0]                len,
  output pcact_pkg::pipe_ctl_t              out_ctl,
  output logic [pcact_pkg::FRAC_Q-1:0]      u
);

  localparam int NQ = pcact_pkg::FRAC_Q;

  pcact_pkg::pipe_ctl_t ctl [0:NQ];
  logic [TW-1:0]        rem [0:NQ];
  logic [TW-1:0]        lq  [0:NQ];
  logic [NQ-1:0]        q   [0:NQ];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl[0].valid <= 1'b0;
    end else begin
      ctl[0].valid <= in_ctl.valid;
    end
    ctl[0].phase <= in_ctl.phase;
    rem[0] <= r;
    lq[0]  <= len;
    q[0]   <= '0;
  end

  for (genvar i = 1; i <= NQ; i++) begin : g_step
    logic [TW:0] rem_s;
    logic [TW:0] rem_d;
    logic        take;
    assign rem_s = {rem[i-1], 1'b0};
    assign rem_d = rem_s - {1'b0, lq[i-1]};
    assign take  = (rem_s >= {1'b0, lq[i-1]});
    always_ff @(posedge clk) begin
      if (rst) begin
        ctl[i].valid <= 1'b0;
      end else begin
        ctl[i].valid <= ctl[i-1].valid;
      end
      ctl[i].phase <= ctl[i-1].phase;
      rem[i] <= take ? rem_d[TW-1:0] : rem_s[TW-1:0];
      lq[i]  <= lq[i-1];
      q[i]   <= {q[i-1][NQ-2:0], take};
    end
  end

  assign out_ctl = ctl[NQ];
  assign u       = q[NQ];

endmodule
`default_nettype wire

/* src/pcact_cos.sv */
`default_nettype none
// Cosine of pi*u by a Taylor series, three stages per term, then the
// half-wave shaping and rounding to the output format.
module pcact_cos #(
  parameter int FB = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire pcact_pkg::pipe_ctl_t         in_ctl,
  input  wire logic [pcact_pkg::FRAC_Q-1:0] u,
  output logic                              done,
  output logic [FB:0]                       activation,
  output logic [1:0]                        phase
);

  localparam int N = pcact_pkg::TAYLOR_TERMS;
  localparam logic [31:0] ONE = 32'd1 << 30;

  // Input, fold and pi scaling, square.
  pcact_pkg::pipe_ctl_t c0, c1, c2, c3;
  logic [29:0] u0, v1;
  logic        n1, n2, n3;
  logic [30:0] x2r;
  logic [31:0] x2s;
  logic [61:0] pm, sq;

  assign pm = pcact_pkg::PI_Q30 * v1;
  assign sq = x2r * x2r;

  always_ff @(posedge clk) begin
    if (rst) begin
      c0.valid <= 1'b0;
      c1.valid <= 1'b0;
      c2.valid <= 1'b0;
      c3.valid <= 1'b0;
    end else begin
      c0.valid <= in_ctl.valid;
      c1.valid <= c0.valid;
      c2.valid <= c1.valid;
      c3.valid <= c2.valid;
    end
    c0.phase <= in_ctl.phase;
    c1.phase <= c0.phase;
    c2.phase <= c1.phase;
    c3.phase <= c2.phase;
    u0  <= u;
    n1  <= u0[29];
    v1  <= u0[29] ? 30'(ONE - {2'b0, u0}) : u0;
    n2  <= n1;
    x2r <= pm[60:30];
    n3  <= n2;
    x2s <= sq[61:30];
  end

  // Taylor chain. Index 0 holds the square and the first term.
  pcact_pkg::pipe_ctl_t ctc [0:N];
  logic                 ngc [0:N];
  logic [31:0]          x2c [0:N];
  logic [31:0]          tt  [0:N];
  logic signed [33:0]   ss  [0:N];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctc[0].valid <= 1'b0;
    end else begin
      ctc[0].valid <= c3.valid;
    end
    ctc[0].phase <= c3.phase;
    ngc[0] <= n3;
    x2c[0] <= x2s;
    tt[0]  <= ONE;
    ss[0]  <= '0;
  end

  for (genvar k = 1; k <= N; k++) begin : g_term
    pcact_pkg::pipe_ctl_t cta, ctb;
    logic               nga, ngb;
    logic [31:0]        x2a, x2b, na, nb, qb, rr, qn;
    logic signed [33:0] sa, sb, sn;
    logic [63:0]        pa, pb;
    logic [40:0]        pc;

    assign pa = tt[k-1] * x2c[k-1];
    if ((k % 2) == 1) begin : g_add
      assign sn = ss[k-1] + $signed({2'b0, tt[k-1]});
    end else begin : g_sub
      assign sn = ss[k-1] - $signed({2'b0, tt[k-1]});
    end
    assign pb = na * pcact_pkg::TAYLOR_RECIP[k];
    assign pc = qb * pcact_pkg::TAYLOR_DIV[k];
    assign rr = nb - pc[31:0];
    assign qn = (rr >= {23'b0, pcact_pkg::TAYLOR_DIV[k]}) ? (qb + 32'd1) : qb;

    always_ff @(posedge clk) begin
      if (rst) begin
        cta.valid    <= 1'b0;
        ctb.valid    <= 1'b0;
        ctc[k].valid <= 1'b0;
      end else begin
        cta.valid    <= ctc[k-1].valid;
        ctb.valid    <= cta.valid;
        ctc[k].valid <= ctb.valid;
      end
      cta.phase    <= ctc[k-1].phase;
      ctb.phase    <= cta.phase;
      ctc[k].phase <= ctb.phase;
      nga    <= ngc[k-1];
      ngb    <= nga;
      ngc[k] <= ngb;
      x2a    <= x2c[k-1];
      x2b    <= x2a;
      x2c[k] <= x2b;
      na     <= pa[61:30];
      sa     <= sn;
      nb     <= na;
      qb     <= pb[63:32];
      sb     <= sa;
      tt[k]  <= qn;
      ss[k]  <= sb;
    end
  end

  // Last term, clamp, half-wave shaping, rounding.
  pcact_pkg::pipe_ctl_t cf1, cf2;
  logic                 nf1;
  logic signed [33:0]   sum_f, sum_n;
  logic [30:0]          mag, hq;
  logic [31:0]          val;
  logic                 sub;
  logic [31:0]          rnd;
  logic [FB+1:0]        ar;

  if ((N % 2) == 1) begin : g_last_sub
    assign sum_n = ss[N] - $signed({2'b0, tt[N]});
  end else begin : g_last_add
    assign sum_n = ss[N] + $signed({2'b0, tt[N]});
  end

  assign mag = (sum_f < 0) ? 31'd0 :
               (sum_f > $signed({2'b0, ONE})) ? ONE[30:0] : sum_f[30:0];
  assign sub = (cf1.phase == pcact_pkg::PHASE_CONTRACT) != nf1;
  assign val = sub ? (ONE - {1'b0, mag}) : (ONE + {1'b0, mag});
  assign rnd = {1'b0, hq} + (32'd1 << (29 - FB));
  assign ar  = rnd[31:30-FB];

  always_ff @(posedge clk) begin
    if (rst) begin
      cf1.valid <= 1'b0;
      cf2.valid <= 1'b0;
      done      <= 1'b0;
    end else begin
      cf1.valid <= ctc[N].valid;
      cf2.valid <= cf1.valid;
      done      <= cf2.valid;
    end
    cf1.phase <= ctc[N].phase;
    cf2.phase <= cf1.phase;
    nf1   <= ngc[N];
    sum_f <= sum_n;
    hq    <= val[31:1];
    if (!cf2.valid || cf2.phase == pcact_pkg::PHASE_IDLE) begin
      activation <= '0;
    end else if (ar > (FB+2)'(1 << FB)) begin
      activation <= (FB+1)'(1 << FB);
    end else begin
      activation <= ar[FB:0];
    end
    phase <= cf2.valid ? cf2.phase : pcact_pkg::PHASE_IDLE;
  end

endmodule
`default_nettype wire

/* src/piecewise_cosine_activation.sv */
`default_nettype none
// Piecewise cosine activation. Each request carries one time sample; the
// block answers every request with exactly one result (activation in
// Q1.FRAC_BITS and the phase code), raised on done for a single cycle. The
// block never stalls: busy stays low, a request may be issued on every clock,
// and the receiver must take each result in the cycle in which done is high,
// since there is no way to hold results back. Results leave in request order
// after passing the two bit-per-stage dividers (the period reduction and the
// window fraction) and the Taylor cosine chain, which spends three stages on
// each of its nine terms. Configuration registers are written through cfg_we,
// cfg_index and cfg_data and must only change while no request is in flight.
module piecewise_cosine_activation #(
  parameter int TIME_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [TIME_WIDTH-1:0] time_tick,
  output logic                       done,
  output logic [FRAC_BITS:0]         activation,
  output logic [1:0]                 phase,
  input  wire logic                  cfg_we,
  input  wire logic [2:0]            cfg_index,
  input  wire logic [TIME_WIDTH-1:0] cfg_data
);

  `include "piecewise_cosine_activation_assert.svh"

  // Configuration registers. Unknown indexes are ignored.
  logic [TIME_WIDTH-1:0] period_ticks;
  logic [TIME_WIDTH-1:0] contract_begin;
  logic [TIME_WIDTH-1:0] relax_begin;
  logic [TIME_WIDTH-1:0] contract_length;
  logic [TIME_WIDTH-1:0] relax_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      period_ticks    <= TIME_WIDTH'(pcact_pkg::PERIOD_RESET);
      contract_begin  <= '0;
      relax_begin     <= '0;
      contract_length <= '0;
      relax_length    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pcact_pkg::REG_PERIOD:          period_ticks    <= cfg_data;
        pcact_pkg::REG_CONTRACT_BEGIN:  contract_begin  <= cfg_data;
        pcact_pkg::REG_RELAX_BEGIN:     relax_begin     <= cfg_data;
        pcact_pkg::REG_CONTRACT_LENGTH: contract_length <= cfg_data;
        pcact_pkg::REG_RELAX_LENGTH:    relax_length    <= cfg_data;
        default: ;
      endcase
    end
  end

  // The pipeline takes a request on every clock.
  assign busy = 1'b0;

  // Both windows are tested side by side; the contraction window wins when
  // both are hit.
  logic                  vc, vr, hit_c, hit_r;
  logic [TIME_WIDTH-1:0] pos_c, pos_r;

  pcact_mod #(.TW(TIME_WIDTH)) u_mod_contract (
    .clk(clk), .rst(rst), .in_valid(start), .t(time_tick),
    .begin_tick(contract_begin), .len(contract_length), .period(period_ticks),
    .out_valid(vc), .hit(hit_c), .pos(pos_c)
  );

  pcact_mod #(.TW(TIME_WIDTH)) u_mod_relax (
    .clk(clk), .rst(rst), .in_valid(start), .t(time_tick),
    .begin_tick(relax_begin), .len(relax_length), .period(period_ticks),
    .out_valid(vr), .hit(hit_r), .pos(pos_r)
  );

  pcact_pkg::pipe_ctl_t  sel_ctl;
  logic [TIME_WIDTH-1:0] sel_r, sel_len;

  always_comb begin
    sel_ctl.valid = vc & vr;
    if (hit_c) begin
      sel_ctl.phase = pcact_pkg::PHASE_CONTRACT;
      sel_r         = pos_c;
      sel_len       = contract_length;
    end else if (hit_r) begin
      sel_ctl.phase = pcact_pkg::PHASE_RELAX;
      sel_r         = pos_r;
      sel_len       = relax_length;
    end else begin
      sel_ctl.phase = pcact_pkg::PHASE_IDLE;
      sel_r         = '0;
      sel_len       = '0;
    end
  end

  // Position within the window as a Q0.30 fraction.
  pcact_pkg::pipe_ctl_t               frac_ctl;
  logic [pcact_pkg::FRAC_Q-1:0]       frac_u;

  pcact_frac #(.TW(TIME_WIDTH)) u_frac (
    .clk(clk), .rst(rst), .in_ctl(sel_ctl), .r(sel_r), .len(sel_len),
    .out_ctl(frac_ctl), .u(frac_u)
  );

  // Cosine shaping and output registers.
  pcact_cos #(.FB(FRAC_BITS)) u_cos (
    .clk(clk), .rst(rst), .in_ctl(frac_ctl), .u(frac_u),
    .done(done), .activation(activation), .phase(phase)
  );

  `PCA_ASSERT_SAME(a_idle_zero, done && phase == pcact_pkg::PHASE_IDLE, activation == '0)
  `PCA_ASSERT_SAME(a_act_range, done, activation <= (FRAC_BITS+1)'(1 << FRAC_BITS))
  `PCA_ASSERT_SAME(a_quiet, !done, activation == '0 && phase == pcact_pkg::PHASE_IDLE)

endmodule
`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps

// Piecewise cosine activation testbench.
module tb;
  import pcact_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  // Clock edges waited after a batch has drained, before new register writes.
  localparam int DRAIN_CYCLES = 120;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] time_tick = '0;
  logic        done;
  logic [16:0] activation;
  logic [1:0]  phase;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // One expected result of the activation block.
  typedef struct {
    logic [16:0] level;
    phase_t      ph;
  } activation_t;

  logic [31:0] pending_times[$];
  activation_t expected_levels[$];

  // Shadow copies of the configuration registers.
  logic [63:0] period_sh = 64'd1000000;
  logic [63:0] contract_begin_sh = '0;
  logic [63:0] relax_begin_sh = '0;
  logic [63:0] contract_len_sh = '0;
  logic [63:0] relax_len_sh = '0;

  bit failed = 1'b0;
  int sent = 0;
  int idle_cycles = 0;

  piecewise_cosine_activation dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .time_tick(time_tick),
    .done(done), .activation(activation), .phase(phase),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Cycle position of a sample inside one window; returns 0 on a miss.
  // A sample before the window start only hits when the distance is a whole
  // number of periods, and then the position is zero.
  function automatic bit window_pos(input logic [63:0] t, input logic [63:0] base,
                                    input logic [63:0] len, output logic [63:0] pos);
    pos = '0;
    if (period_sh == 0 || len == 0) return 1'b0;
    if (t >= base) begin
      pos = (t - base) % period_sh;
    end else begin
      if (((base - t) % period_sh) != 0) return 1'b0;
      pos = '0;
    end
    return pos < len;
  endfunction

  // Fixed-point cos(pi * pos / len) in Q30, signed.
  function automatic longint signed cosine_q30(input logic [63:0] pos,
                                               input logic [63:0] len);
    logic [63:0] rem;
    logic [63:0] frac;
    logic [63:0] v;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint signed sum;
    bit neg;
    rem = pos;
    frac = '0;
    // Restoring division gives the window fraction in Q0.30.
    for (int i = 0; i < 30; i++) begin
      rem = rem << 1;
      frac = frac << 1;
      if (rem >= len) begin
        rem = rem - len;
        frac[0] = 1'b1;
      end
    end
    // Fold the second half of the window onto the first and flip the sign.
    neg = frac >= (64'd1 << 29);
    v = neg ? (64'd1 << 30) - frac : frac;
    x = (64'(PI_Q30) * v) >> 30;
    x2 = (x * x) >> 30;
    term = 64'd1 << 30;
    sum = longint'(1) << 30;
    for (int k = 1; k <= TAYLOR_TERMS; k++) begin
      term = ((term * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
      if (k % 2 == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    if (sum > (longint'(1) << 30)) sum = longint'(1) << 30;
    return neg ? -sum : sum;
  endfunction

  // Rounds a Q30 level half up to Q1.16 and saturates at 1.0.
  function automatic logic [16:0] round_level(input longint signed h);
    logic [63:0] a;
    a = (64'(h) + (64'd1 << 13)) >> 14;
    return (a > 64'd65536) ? 17'd65536 : a[16:0];
  endfunction

  // Predicts the result of one time sample under the current registers.
  function automatic activation_t predict_activation(input logic [31:0] t);
    activation_t res;
    logic [63:0] pos;
    longint signed c;
    res.level = '0;
    res.ph = PHASE_IDLE;
    if (window_pos(64'(t), contract_begin_sh, contract_len_sh, pos)) begin
      c = cosine_q30(pos, contract_len_sh);
      res.level = round_level(((longint'(1) << 30) - c) / 2);
      res.ph = PHASE_CONTRACT;
    end else if (window_pos(64'(t), relax_begin_sh, relax_len_sh, pos)) begin
      c = cosine_q30(pos, relax_len_sh);
      res.level = round_level(((longint'(1) << 30) + c) / 2);
      res.ph = PHASE_RELAX;
    end
    return res;
  endfunction

  // Request driver. A request is taken at an edge with start high and busy
  // low; start is held while busy is high. Requests 600 to 899 go out with
  // no gaps at all; for the rest, start stays low with a chance of 14 in 100.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_levels.push_back(predict_activation(time_tick));
        sent <= sent + 1;
      end
      if (start && busy) begin
        start <= 1'b1;
      end else if (pending_times.size() > 0 &&
                   ((sent >= 600 && sent < 900) || $urandom_range(99) >= 14)) begin
        start <= 1'b1;
        time_tick <= pending_times.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Result monitor. Results cannot be held off, so each strobe is compared
  // right away against the oldest prediction.
  always @(posedge clk) begin
    activation_t exp_res;
    if (!rst && done) begin
      if (expected_levels.size() == 0) begin
        $display("%0t: unexpected result activation=%0d phase=%0d",
                 $time, activation, phase);
        failed = 1'b1;
      end else begin
        exp_res = expected_levels.pop_front();
        if (activation !== exp_res.level) begin
          $display("%0t: activation expected %0d actual %0d",
                   $time, exp_res.level, activation);
          failed = 1'b1;
        end
        if (phase !== exp_res.ph) begin
          $display("%0t: phase expected %0d actual %0d",
                   $time, exp_res.ph, phase);
          failed = 1'b1;
        end
      end
    end
  end

  // Watchdog: counts cycles with work outstanding in which neither a
  // request nor a result moves.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done ||
        (pending_times.size() == 0 && expected_levels.size() == 0 && !start)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Writes one register and keeps its shadow copy in step.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_PERIOD: period_sh = 64'(val);
      REG_CONTRACT_BEGIN: contract_begin_sh = 64'(val);
      REG_RELAX_BEGIN: relax_begin_sh = 64'(val);
      REG_CONTRACT_LENGTH: contract_len_sh = 64'(val);
      REG_RELAX_LENGTH: relax_len_sh = 64'(val);
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_windows(input logic [31:0] per, input logic [31:0] cb,
                             input logic [31:0] rb, input logic [31:0] cl,
                             input logic [31:0] rl);
    write_reg(REG_PERIOD, per);
    write_reg(REG_CONTRACT_BEGIN, cb);
    write_reg(REG_RELAX_BEGIN, rb);
    write_reg(REG_CONTRACT_LENGTH, cl);
    write_reg(REG_RELAX_LENGTH, rl);
  endtask

  // Random sample time. Most samples land near a window start, a whole
  // number of periods away, so the edges and the inside of both windows are
  // hit often; others sit before a start, are 0 or all ones, or are random.
  function automatic logic [31:0] pick_time();
    logic [63:0] base;
    logic [63:0] len;
    logic [63:0] k;
    logic [63:0] t;
    bit rel;
    rel = $urandom_range(1);
    base = rel ? relax_begin_sh : contract_begin_sh;
    len = rel ? relax_len_sh : contract_len_sh;
    k = 64'($urandom_range(3));
    case ($urandom_range(9))
      0, 1, 2, 3, 4: t = base + k * period_sh + (64'($urandom) % (len + 2));
      5: t = base + k * period_sh + len - 64'($urandom_range(1));
      6: t = base - k * period_sh - 64'($urandom_range(1));
      7: t = $urandom_range(1) ? 64'hFFFF_FFFF : 64'h0;
      default: t = 64'($urandom);
    endcase
    return t[31:0];
  endfunction

  // Queues a batch and waits until all of its results have come back and the
  // drain wait is over, so the next register writes find the block idle.
  task automatic run_batch(input int count);
    for (int i = 0; i < count; i++) pending_times.push_back(pick_time());
    wait (pending_times.size() == 0 && !start && expected_levels.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [31:0] per;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Reset values: both windows disabled, every sample is idle.
    pending_times.push_back(32'd0);
    pending_times.push_back(32'hFFFF_FFFF);
    run_batch(100);

    // A plain cycle with directed samples at the window edges, before the
    // start, and a whole period after the start.
    set_windows(32'd1000, 32'd100, 32'd600, 32'd400, 32'd300);
    pending_times.push_back(32'd100);
    pending_times.push_back(32'd101);
    pending_times.push_back(32'd300);
    pending_times.push_back(32'd499);
    pending_times.push_back(32'd500);
    pending_times.push_back(32'd600);
    pending_times.push_back(32'd750);
    pending_times.push_back(32'd899);
    pending_times.push_back(32'd900);
    pending_times.push_back(32'd99);
    pending_times.push_back(32'd1100);
    pending_times.push_back(32'hFFFF_FFFF);
    pending_times.push_back(32'd0);
    run_batch(250);

    // Period of one tick: the position is always zero.
    set_windows(32'd1, 32'd0, 32'd0, 32'd1, 32'd1);
    run_batch(150);

    // All registers but the relaxation start at their largest values.
    set_windows(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    pending_times.push_back(32'hFFFF_FFFE);
    pending_times.push_back(32'h7FFF_FFFF);
    run_batch(250);

    // Overlapping windows: contraction wins where both hit.
    set_windows(32'd7, 32'd3, 32'd5, 32'd3, 32'd7);
    run_batch(250);

    // Contraction disabled by a zero length.
    set_windows(32'd50, 32'd10, 32'd30, 32'd0, 32'd20);
    run_batch(250);

    // Random settings.
    for (int n = 0; n < 4; n++) begin
      per = $urandom_range(1, 1 << 20);
      set_windows(per, $urandom, $urandom, $urandom_range(0, per + 10),
                  $urandom_range(0, per + 10));
      run_batch(150);
    end

    if (!failed) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
